// File: rtl/mtep_pkg.sv
// shared types and constants of the midi track event parser
`default_nettype none

package mtep_pkg;

  localparam int unsigned NumChannels = 16;
  localparam int unsigned ChanW = $clog2(NumChannels);
  localparam int unsigned OutDataW = 120;

  // parse phases
  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_META_LEN  = 4'd5,
    PH_META_BODY = 4'd6,
    PH_SYX_LEN   = 4'd7,
    PH_SYX_BODY  = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    KIND_NOTE      = 3'd0,
    KIND_CONTROL   = 3'd1,
    KIND_KEY_PRES  = 3'd2,
    KIND_BEND      = 3'd3,
    KIND_CHAN_PRES = 3'd4,
    KIND_TEMPO     = 3'd5,
    KIND_ERROR     = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ERR_TRUNCATED  = 3'd0,
    ERR_VARLEN     = 3'd1,
    ERR_OVERFLOW   = 3'd2,
    ERR_BAD_DATA   = 3'd3,
    ERR_NO_RUNNING = 3'd4,
    ERR_UNSUPP     = 3'd5
  } err_e;

  // channel message types (upper status nibble)
  localparam logic [3:0] MSG_NOTE_OFF  = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON   = 4'h9;
  localparam logic [3:0] MSG_KEY_PRES  = 4'ha;
  localparam logic [3:0] MSG_CONTROL   = 4'hb;
  localparam logic [3:0] MSG_PROGRAM   = 4'hc;
  localparam logic [3:0] MSG_CHAN_PRES = 4'hd;
  localparam logic [3:0] MSG_BEND      = 4'he;

  localparam logic [7:0] STATUS_CHAN_MAX = 8'hef;
  localparam logic [7:0] STATUS_SYSEX    = 8'hf0;
  localparam logic [7:0] STATUS_ESCAPE   = 8'hf7;
  localparam logic [7:0] STATUS_META     = 8'hff;
  localparam logic [7:0] META_TEMPO      = 8'h51;
  localparam logic [27:0] TEMPO_LEN      = 28'd3;
  localparam logic [6:0] CC_BANK_MSB     = 7'd0;
  localparam logic [6:0] CC_BANK_LSB     = 7'd32;
  localparam logic [2:0] VarlenMaxBytes  = 3'd4;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       track_start;
    logic       track_last;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic [ChanW-1:0]   channel;
    logic [31:0]        tick;
    logic [6:0]         key;
    logic [6:0]         value;
    logic               note_on;
    logic [6:0]         controller;
    logic signed [13:0] bend_val;
    logic [6:0]         program_res;
    logic [13:0]        bank;
    logic [23:0]        tempo;
    err_e               error_code;
  } res_t;

  typedef struct packed {
    phase_e phase;
    logic   err_latched;
    logic   tempo_armed;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/mtep_in_reg.sv
// input register stage holding one track byte item
`default_nettype none

module mtep_in_reg (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            valid_i,
  output logic           ready_o,
  input  mtep_pkg::in_t  item_i,
  input  wire            adv_i,
  output logic           valid_o,
  output mtep_pkg::in_t  item_o
);

  logic          valid_q;
  mtep_pkg::in_t item_q;

  // take a new item when empty or when the held one moves on this cycle
  assign ready_o = !valid_q || adv_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mtep_parser.sv
// track parse state, per-channel tables and one-byte step logic
`default_nettype none

module mtep_parser (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  adv_i,
  input  mtep_pkg::in_t        item_i,
  output logic                 res_valid_o,
  output mtep_pkg::res_t       res_o,
  output mtep_pkg::status_t    status_o
);

  localparam int unsigned N = mtep_pkg::NumChannels;

  mtep_pkg::phase_e ph_q, ph_b, ph_d;
  logic [7:0]  run_q, run_b, run_d;
  logic [31:0] tick_q, tick_b, tick_d;
  logic [27:0] acc_q, acc_b, acc_d;
  logic [2:0]  cnt_q, cnt_b, cnt_d;
  logic [7:0]  cur_q, cur_b, cur_d;
  logic [6:0]  first_q, first_b, first_d;
  logic [7:0]  meta_q, meta_b, meta_d;
  logic [27:0] pay_q, pay_b, pay_d;
  logic [23:0] tmp_q, tmp_b, tmp_d;
  logic        arm_q, arm_b, arm_d;
  logic        err_q, err_b, err_d;

  logic [6:0] prog_q [N];
  logic [6:0] prog_d [N];
  logic [6:0] msb_q  [N];
  logic [6:0] msb_d  [N];
  logic [6:0] lsb_q  [N];
  logic [6:0] lsb_d  [N];

  logic [7:0]  b;
  logic [27:0] acc_nx;
  logic [2:0]  cnt_nx;
  logic        vl_long;
  logic        vl_done;
  logic [32:0] tick_sum;
  logic        chan_data;
  logic        finish;
  logic [6:0]  fa;
  logic [6:0]  fb;
  logic [3:0]  mtype;
  logic [mtep_pkg::ChanW-1:0] ch;
  logic        err_hit;
  mtep_pkg::err_e err_code;
  logic        emit;
  mtep_pkg::res_t res;

  assign b        = item_i.track_byte;
  assign acc_nx   = {acc_b[20:0], b[6:0]};
  assign cnt_nx   = cnt_b + 3'd1;
  assign vl_done  = !b[7];
  assign vl_long  = b[7] && (cnt_nx >= mtep_pkg::VarlenMaxBytes);
  assign tick_sum = {1'b0, tick_b} + {5'd0, acc_nx};

  // a track start clears the per-track state before the byte is parsed
  always_comb begin
    if (item_i.track_start) begin
      ph_b = mtep_pkg::PH_DELTA; run_b = '0; tick_b = '0; acc_b = '0; cnt_b = '0;
      cur_b = '0; first_b = '0; meta_b = '0; pay_b = '0; tmp_b = '0;
      arm_b = 1'b0; err_b = 1'b0;
    end else begin
      ph_b = ph_q; run_b = run_q; tick_b = tick_q; acc_b = acc_q; cnt_b = cnt_q;
      cur_b = cur_q; first_b = first_q; meta_b = meta_q; pay_b = pay_q; tmp_b = tmp_q;
      arm_b = arm_q; err_b = err_q;
    end
  end

  always_comb begin
    ph_d = ph_b; run_d = run_b; tick_d = tick_b; acc_d = acc_b; cnt_d = cnt_b;
    cur_d = cur_b; first_d = first_b; meta_d = meta_b; pay_d = pay_b; tmp_d = tmp_b;
    arm_d = arm_b; err_d = err_b;
    prog_d = prog_q;
    msb_d  = msb_q;
    lsb_d  = lsb_q;
    chan_data = 1'b0;
    finish    = 1'b0;
    fa        = '0;
    fb        = '0;
    err_hit   = 1'b0;
    err_code  = mtep_pkg::ERR_TRUNCATED;
    emit      = 1'b0;
    res       = '0;

    if (!err_b) begin
      unique case (ph_b)
        mtep_pkg::PH_DELTA: begin
          acc_d = acc_nx;
          cnt_d = cnt_nx;
          if (vl_long) begin
            err_hit = 1'b1; err_code = mtep_pkg::ERR_VARLEN;
          end else if (vl_done) begin
            if (tick_sum[32]) begin
              err_hit = 1'b1; err_code = mtep_pkg::ERR_OVERFLOW;
            end else begin
              tick_d = tick_sum[31:0];
              acc_d  = '0;
              cnt_d  = '0;
              ph_d   = mtep_pkg::PH_STATUS;
            end
          end
        end
        mtep_pkg::PH_STATUS: begin
          if (b[7]) begin
            run_d = (b <= mtep_pkg::STATUS_CHAN_MAX) ? b : 8'd0;
            cur_d = b;
            if (b == mtep_pkg::STATUS_META) begin
              ph_d = mtep_pkg::PH_META_TYPE;
            end else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESCAPE) begin
              ph_d = mtep_pkg::PH_SYX_LEN;
            end else if (b > mtep_pkg::STATUS_CHAN_MAX) begin
              err_hit = 1'b1; err_code = mtep_pkg::ERR_UNSUPP;
            end else begin
              ph_d = mtep_pkg::PH_DATA1;
            end
          end else if (run_b == 8'd0) begin
            err_hit = 1'b1; err_code = mtep_pkg::ERR_NO_RUNNING;
          end else begin
            // running status: this byte is the first data byte
            cur_d     = run_b;
            chan_data = 1'b1;
          end
        end
        mtep_pkg::PH_DATA1, mtep_pkg::PH_DATA2: begin
          chan_data = 1'b1;
        end
        mtep_pkg::PH_META_TYPE: begin
          meta_d = b;
          ph_d   = mtep_pkg::PH_META_LEN;
        end
        mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYX_LEN: begin
          acc_d = acc_nx;
          cnt_d = cnt_nx;
          if (vl_long) begin
            err_hit = 1'b1; err_code = mtep_pkg::ERR_VARLEN;
          end else if (vl_done) begin
            pay_d = acc_nx;
            arm_d = (ph_b == mtep_pkg::PH_META_LEN) && (meta_b == mtep_pkg::META_TEMPO)
                    && (acc_nx == mtep_pkg::TEMPO_LEN);
            tmp_d = '0;
            acc_d = '0;
            cnt_d = '0;
            if (acc_nx == 28'd0) begin
              ph_d = mtep_pkg::PH_DELTA;
            end else if (ph_b == mtep_pkg::PH_META_LEN) begin
              ph_d = mtep_pkg::PH_META_BODY;
            end else begin
              ph_d = mtep_pkg::PH_SYX_BODY;
            end
          end
        end
        mtep_pkg::PH_META_BODY, mtep_pkg::PH_SYX_BODY: begin
          tmp_d = {tmp_b[15:0], b};
          pay_d = pay_b - 28'd1;
          if (pay_d == 28'd0) begin
            ph_d = mtep_pkg::PH_DELTA;
            if (arm_b) begin
              arm_d     = 1'b0;
              emit      = 1'b1;
              res.kind  = mtep_pkg::KIND_TEMPO;
              res.tempo = tmp_d;
            end
          end
        end
        default: begin
          ph_d = mtep_pkg::PH_DELTA;
        end
      endcase

      if (chan_data) begin
        if (b[7]) begin
          err_hit = 1'b1; err_code = mtep_pkg::ERR_BAD_DATA;
        end else if (ph_b != mtep_pkg::PH_DATA2) begin
          first_d = b[6:0];
          if (cur_d[7:4] == mtep_pkg::MSG_PROGRAM || cur_d[7:4] == mtep_pkg::MSG_CHAN_PRES) begin
            finish = 1'b1;
            fa     = b[6:0];
          end else begin
            ph_d = mtep_pkg::PH_DATA2;
          end
        end else begin
          finish = 1'b1;
          fa     = first_b;
          fb     = b[6:0];
        end
      end

      mtype = cur_d[7:4];
      ch    = cur_d[mtep_pkg::ChanW-1:0];
      if (finish) begin
        ph_d = mtep_pkg::PH_DELTA;
        if (mtype == mtep_pkg::MSG_PROGRAM) begin
          prog_d[ch] = fa;
        end else begin
          if (mtype == mtep_pkg::MSG_CONTROL && fa == mtep_pkg::CC_BANK_MSB) begin
            msb_d[ch] = fb;
          end
          if (mtype == mtep_pkg::MSG_CONTROL && fa == mtep_pkg::CC_BANK_LSB) begin
            lsb_d[ch] = fb;
          end
          emit            = 1'b1;
          res.channel     = ch;
          res.program_res = prog_d[ch];
          res.bank        = {msb_d[ch], lsb_d[ch]};
          unique case (mtype)
            mtep_pkg::MSG_CONTROL: begin
              res.kind = mtep_pkg::KIND_CONTROL; res.controller = fa; res.value = fb;
            end
            mtep_pkg::MSG_KEY_PRES: begin
              res.kind = mtep_pkg::KIND_KEY_PRES; res.key = fa; res.value = fb;
            end
            mtep_pkg::MSG_BEND: begin
              // (msb << 7 | lsb) - 8192 in 14 bits flips the top bit
              res.kind     = mtep_pkg::KIND_BEND;
              res.bend_val = {~fb[6], fb[5:0], fa};
            end
            mtep_pkg::MSG_CHAN_PRES: begin
              res.kind = mtep_pkg::KIND_CHAN_PRES; res.value = fa;
            end
            default: begin
              res.kind    = mtep_pkg::KIND_NOTE;
              res.key     = fa;
              res.value   = fb;
              res.note_on = (mtype == mtep_pkg::MSG_NOTE_ON) && (fb != 7'd0);
            end
          endcase
        end
      end
    end else begin
      mtype = cur_d[7:4];
      ch    = cur_d[mtep_pkg::ChanW-1:0];
    end

    // last byte of the track leaves an event or delta open
    if (!err_b && !err_hit && !emit && item_i.track_last
        && (ph_d != mtep_pkg::PH_DELTA || cnt_d != 3'd0)) begin
      err_hit  = 1'b1;
      err_code = mtep_pkg::ERR_TRUNCATED;
    end

    if (err_hit) begin
      res            = '0;
      res.kind       = mtep_pkg::KIND_ERROR;
      res.error_code = err_code;
      err_d          = 1'b1;
      emit           = 1'b1;
    end
    res.tick = tick_d;
  end

  assign res_valid_o = adv_i && emit;
  assign res_o       = res;
  assign status_o    = '{phase: ph_q, err_latched: err_q, tempo_armed: arm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= mtep_pkg::PH_DELTA; run_q <= '0; tick_q <= '0; acc_q <= '0; cnt_q <= '0;
      cur_q <= '0; first_q <= '0; meta_q <= '0; pay_q <= '0; tmp_q <= '0;
      arm_q <= 1'b0; err_q <= 1'b0;
      prog_q <= '{default: '0};
      msb_q  <= '{default: '0};
      lsb_q  <= '{default: '0};
    end else if (adv_i) begin
      ph_q <= ph_d; run_q <= run_d; tick_q <= tick_d; acc_q <= acc_d; cnt_q <= cnt_d;
      cur_q <= cur_d; first_q <= first_d; meta_q <= meta_d; pay_q <= pay_d; tmp_q <= tmp_d;
      arm_q <= arm_d; err_q <= err_d;
      prog_q <= prog_d;
      msb_q  <= msb_d;
      lsb_q  <= lsb_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mtep_out_reg.sv
// result register in front of the output stream
`default_nettype none

module mtep_out_reg (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             load_i,
  input  mtep_pkg::res_t  res_i,
  output logic            space_o,
  output logic            valid_o,
  input  wire             ready_i,
  output mtep_pkg::res_t  res_o
);

  logic           valid_q;
  mtep_pkg::res_t res_q;

  // free when empty or when the held item is taken this cycle
  assign space_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && space_o) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/midi_track_event_parser.sv
// top level of the midi track event parser
`default_nettype none

// Parses a standard MIDI track body one byte per item and sustains one byte
// per clock cycle unless the output stalls. A byte is held in the input
// register while the step logic updates the parse state; its result is loaded
// into the output register. Only bytes that complete a channel event, a tempo
// meta event or raise an error produce a result; program changes, delta bytes
// and skipped sysex/meta payloads produce none. Back-pressure on the output
// stalls the input register and then the input side. Per-channel program and
// bank tables are 16 entries of flip-flops cleared by reset only; a track
// start clears tick, running status, parse phase and error latch.

module midi_track_event_parser (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  [7:0]                    s_axis_tdata,  // track_byte
  input  wire                           s_axis_tuser,  // track_start
  input  wire                           s_axis_tlast,  // track_last
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  // channel, tick, key, value, note_on, controller, bend_val, program_res,
  // bank, tempo, error_code
  output logic [mtep_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [2:0]                    m_axis_tuser   // event_kind
);

  mtep_pkg::in_t     in_item;
  mtep_pkg::in_t     s1_item;
  logic              s1_valid;
  logic              adv;
  logic              out_space;
  logic              res_valid;
  mtep_pkg::res_t    res;
  mtep_pkg::res_t    out_res;
  mtep_pkg::status_t st;

  assign in_item = '{track_byte: s_axis_tdata, track_start: s_axis_tuser,
                     track_last: s_axis_tlast};
  assign adv     = s1_valid && out_space;

  mtep_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  mtep_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (st)
  );

  mtep_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .space_o (out_space),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {out_res.error_code, out_res.tempo, out_res.bank, out_res.program_res,
                         out_res.bend_val, out_res.controller, out_res.note_on,
                         out_res.value, out_res.key, out_res.tick, out_res.channel};

`ifndef SYNTH
  // an error result latches the parser until the next track start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.kind == mtep_pkg::KIND_ERROR) |=> st.err_latched)
    else $error("error result without error latch");

  // a pending tempo event only exists while its payload is being read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.tempo_armed |-> (st.phase == mtep_pkg::PH_META_BODY))
    else $error("tempo armed outside meta body");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.kind != mtep_pkg::KIND_ERROR)
      |-> (out_res.error_code == mtep_pkg::ERR_TRUNCATED))
    else $error("error code set on a non-error item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res.kind != mtep_pkg::KIND_BEND) |-> (out_res.bend_val == 14'sd0))
    else $error("bend value set on a non-bend item");
`endif

endmodule

`default_nettype wire
